// ----- src/m65alu_pkg.sv -----
// Shared types, opcodes and flag positions for the 6502 ALU and branch unit.
package m65alu_pkg;

   // Status bit positions
   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_K = 5;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 48;

   // Decimal fixup thresholds and adjustments
   localparam logic [5:0] BCD_LO_MAX = 6'h09;
   localparam logic [5:0] BCD_LO_ADJ = 6'h06;
   localparam logic [9:0] BCD_HI_MAX = 10'h090;
   localparam logic [9:0] BCD_HI_ADJ = 10'h060;
   localparam logic [9:0] BCD_HI_CRY = 10'h010;

   typedef enum logic [4:0] {
      OP_ADC = 5'd0,
      OP_AND = 5'd1,
      OP_ASL = 5'd2,
      OP_BIT = 5'd3,
      OP_CMP = 5'd4,
      OP_BCC = 5'd5,
      OP_BCS = 5'd6,
      OP_BEQ = 5'd7,
      OP_BMI = 5'd8,
      OP_BNE = 5'd9,
      OP_BPL = 5'd10,
      OP_BVC = 5'd11,
      OP_BVS = 5'd12,
      OP_CLC = 5'd13,
      OP_CLD = 5'd14,
      OP_CLI = 5'd15,
      OP_CLV = 5'd16
   } op_type;

   typedef struct packed {
      logic              to_accum;
      logic              page_crossed;
      logic signed [7:0] rel_offset;
      logic [15:0]       next_pc;
      logic [7:0]        status_in;
      logic [7:0]        accum_in;
      logic [7:0]        operand;
      logic [4:0]        op;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  extra_cycles;
      logic [15:0] branch_target;
      logic        branch_taken;
      logic        mem_write;
      logic [7:0]  mem_result;
      logic [7:0]  status_out;
      logic [7:0]  accum_out;
   } rsp_item_type;

endpackage

// ----- src/m65alu_exec.sv -----
// Execute logic: ALU operations, flag updates, branch decision and cycle cost.
module m65alu_exec
   import m65alu_pkg::*;
(
   input  req_item_type req,
   input  logic         decimal_enable,
   output rsp_item_type rsp
);

   logic [7:0]  a;
   logic [7:0]  m;
   logic [7:0]  st;
   logic [7:0]  st_out;
   logic [7:0]  acc;
   logic [7:0]  memv;
   logic        memw;
   logic        cond;
   logic [1:0]  extra;
   logic [8:0]  bin_sum;
   logic [5:0]  lo_raw;
   logic [5:0]  lo_fix;
   logic [9:0]  hi_raw;
   logic [9:0]  hi_mid;
   logic [9:0]  hi_fix;
   logic [7:0]  dec_res;
   logic [7:0]  and_res;
   logic [8:0]  asl_res;
   logic [8:0]  cmp_diff;
   logic [15:0] target;
   logic        use_dec;

   always_comb begin
      a  = req.accum_in;
      m  = req.operand;
      st = req.status_in | (8'h01 << FLAG_K);

      bin_sum = {1'b0, a} + {1'b0, m} + {8'h00, st[FLAG_C]};

      // Nibble-wise decimal add with carry fixups
      lo_raw = {2'b00, a[3:0]} + {2'b00, m[3:0]} + {5'h00, st[FLAG_C]};
      hi_raw = {2'b00, a[7:4], 4'h0} + {2'b00, m[7:4], 4'h0};
      if (lo_raw > BCD_LO_MAX) begin
         lo_fix = lo_raw + BCD_LO_ADJ;
         hi_mid = hi_raw + BCD_HI_CRY;
      end else begin
         lo_fix = lo_raw;
         hi_mid = hi_raw;
      end
      hi_fix  = (hi_mid > BCD_HI_MAX) ? hi_mid + BCD_HI_ADJ : hi_mid;
      dec_res = {hi_fix[7:4], lo_fix[3:0]};
      use_dec = decimal_enable & st[FLAG_D];

      and_res  = a & m;
      asl_res  = req.to_accum ? {a, 1'b0} : {m, 1'b0};
      cmp_diff = {1'b0, a} - {1'b0, m};
      target   = req.next_pc + {{8{req.rel_offset[7]}}, req.rel_offset};
   end

   always_comb begin
      st_out = st;
      acc    = a;
      memv   = 8'h00;
      memw   = 1'b0;
      cond   = 1'b0;
      extra  = 2'd0;
      unique case (req.op)
         OP_ADC: begin
            if (use_dec) begin
               acc            = dec_res;
               st_out[FLAG_C] = |hi_fix[9:8];
               extra          = 2'd1 + {1'b0, req.page_crossed};
            end else begin
               acc            = bin_sum[7:0];
               st_out[FLAG_C] = bin_sum[8];
               st_out[FLAG_V] = (bin_sum[7] ^ a[7]) & (bin_sum[7] ^ m[7]);
               extra          = {1'b0, req.page_crossed};
            end
            st_out[FLAG_Z] = (acc == 8'h00);
            st_out[FLAG_N] = acc[7];
         end
         OP_AND: begin
            acc            = and_res;
            st_out[FLAG_Z] = (and_res == 8'h00);
            st_out[FLAG_N] = and_res[7];
            extra          = {1'b0, req.page_crossed};
         end
         OP_ASL: begin
            st_out[FLAG_C] = asl_res[8];
            st_out[FLAG_Z] = (asl_res[7:0] == 8'h00);
            st_out[FLAG_N] = asl_res[7];
            if (req.to_accum) begin
               acc = asl_res[7:0];
            end else begin
               memv = asl_res[7:0];
               memw = 1'b1;
            end
         end
         OP_BIT: begin
            st_out[FLAG_Z] = (and_res == 8'h00);
            st_out[FLAG_V] = m[6];
            st_out[FLAG_N] = m[7];
         end
         OP_CMP: begin
            st_out[FLAG_C] = ~cmp_diff[8];
            st_out[FLAG_Z] = (a == m);
            st_out[FLAG_N] = cmp_diff[7];
            extra          = {1'b0, req.page_crossed};
         end
         OP_BCC: cond = ~st[FLAG_C];
         OP_BCS: cond = st[FLAG_C];
         OP_BEQ: cond = st[FLAG_Z];
         OP_BMI: cond = st[FLAG_N];
         OP_BNE: cond = ~st[FLAG_Z];
         OP_BPL: cond = ~st[FLAG_N];
         OP_BVC: cond = ~st[FLAG_V];
         OP_BVS: cond = st[FLAG_V];
         OP_CLC: st_out[FLAG_C] = 1'b0;
         OP_CLD: st_out[FLAG_D] = 1'b0;
         OP_CLI: st_out[FLAG_I] = 1'b0;
         OP_CLV: st_out[FLAG_V] = 1'b0;
         default: ;
      endcase

      rsp.accum_out    = acc;
      rsp.status_out   = st_out | (8'h01 << FLAG_K);
      rsp.mem_result   = memv;
      rsp.mem_write    = memw;
      rsp.branch_taken = cond;
      if (cond) begin
         rsp.branch_target = target;
         // An extra cycle more when the target lands on another page
         rsp.extra_cycles  = (target[15:8] != req.next_pc[15:8]) ? 2'd2 : 2'd1;
      end else begin
         rsp.branch_target = req.next_pc;
         rsp.extra_cycles  = extra;
      end
   end

endmodule

// ----- src/mos6502_alu_and_branch_unit.sv -----
// Top level of the 6502 ALU and branch unit: input register, execute, result register.
//
//  Channel | Direction | Handshake              | Payload
//  req     | in        | req_tvalid/req_tready  | req_tuser op, req_tdata operands
//  rsp     | out       | rsp_tvalid/rsp_tready  | rsp_tdata results
//  csr     | in        | csr_valid/csr_ready    | csr_data decimal enable
//
// An accepted item goes to the input register, then to the result register; one item
// is taken every cycle while rsp_tready is high, with the single execute pass between.
// Reset empties both registers and sets decimal enable to 1.
// When rsp_tready is low with a full result register, the input register
// holds its item and req_tready falls only once both are full.
module mos6502_alu_and_branch_unit
   import m65alu_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // operand, accum_in, status_in, next_pc, rel_offset, page_crossed, to_accum, zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // op
   input  logic [4:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // accum_out, status_out, mem_result, mem_write, branch_taken, branch_target,
   // extra_cycles, zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_data
);

   logic         dec_en_ff;
   logic         dec_en_in;
   logic         in_valid_ff;
   logic         in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type exec_rsp;
   logic         out_load;
   logic         in_load;

   assign csr_ready = 1'b1;
   assign dec_en_in = (csr_valid && csr_ready) ? csr_data : dec_en_ff;

   // Advance each stage when the one after it is empty or draining
   assign out_load     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || out_load;
   assign in_load      = req_tvalid && req_tready;
   assign in_valid_in  = in_load || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_en_ff    <= 1'b1;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         dec_en_ff    <= dec_en_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_item_ff.op           <= req_tuser;
         in_item_ff.operand      <= req_tdata[7:0];
         in_item_ff.accum_in     <= req_tdata[15:8];
         in_item_ff.status_in    <= req_tdata[23:16];
         in_item_ff.next_pc      <= req_tdata[39:24];
         in_item_ff.rel_offset   <= req_tdata[47:40];
         in_item_ff.page_crossed <= req_tdata[48];
         in_item_ff.to_accum     <= req_tdata[49];
      end
      if (out_load) begin
         out_item_ff <= exec_rsp;
      end
   end

   m65alu_exec u_exec (
      .req            (in_item_ff),
      .decimal_enable (dec_en_ff),
      .rsp            (exec_rsp)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'h0, out_item_ff};

   ap_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> in_valid_ff)
      else $error("accepted item did not reach the input register");

   ap_bit5_set: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> out_item_ff.status_out[FLAG_K])
      else $error("result status without bit 5");

   ap_write_not_branch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(out_item_ff.mem_write && out_item_ff.branch_taken))
      else $error("memory write and taken branch together");

   ap_taken_costs: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_item_ff.branch_taken) |-> (out_item_ff.extra_cycles != 2'd0))
      else $error("taken branch without extra cycle");

   ap_extra_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_item_ff.extra_cycles != 2'd3))
      else $error("extra cycles out of range");

endmodule
